@@ src/rdu_pkg.sv @@
// ----------------------------------------------------------------------------
// rdu_pkg
// Shared types, widths and rounding helpers for the refraction direction unit.
// ----------------------------------------------------------------------------
package rdu_pkg;

  localparam int VEC_WIDTH = 16;
  localparam int VEC_FRAC  = VEC_WIDTH - 2;
  localparam int IDX_W     = 16;
  localparam int IFRAC     = 16;
  // internal vector component, signed Q.16, magnitude up to 2.0
  localparam int NW        = 19;
  localparam int ETA_W     = 23;
  localparam logic [ETA_W-1:0] ETA_MAX = ETA_W'(64 << IFRAC);
  localparam logic signed [63:0] ONE = 64'sd1 <<< IFRAC;

  typedef logic signed [VEC_WIDTH-1:0] vec_t;
  typedef logic signed [NW-1:0]        ivec_t;

  typedef struct packed {
    vec_t             normal_x;
    vec_t             normal_y;
    vec_t             normal_z;
    vec_t             in_x;
    vec_t             in_y;
    vec_t             in_z;
    logic [IDX_W-1:0] index_from;
    logic [IDX_W-1:0] index_into;
  } in_word_t;

  typedef struct packed {
    logic valid_res;
    vec_t out_x;
    vec_t out_y;
    vec_t out_z;
  } out_word_t;

  // normal and negated incoming direction in internal format
  typedef struct packed {
    ivec_t n0;
    ivec_t n1;
    ivec_t n2;
    ivec_t i0;
    ivec_t i1;
    ivec_t i2;
  } geo_t;

  // x / 2^sh, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] x, input int sh);
    logic [63:0] m;
    logic [63:0] half;
    if (sh <= 0) begin
      return x;
    end
    half = 64'd1 << (sh - 1);
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + half) >> sh;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    return rnd_sh(x, IFRAC);
  endfunction

  function automatic ivec_t to_int(input vec_t x);
    logic signed [63:0] w;
    w = 64'(x);
    if (VEC_FRAC >= IFRAC) begin
      w = rnd_sh(w, VEC_FRAC - IFRAC);
    end else begin
      w = w <<< (IFRAC - VEC_FRAC);
    end
    return NW'(w);
  endfunction

endpackage

@@ src/rdu_delay.sv @@
// ----------------------------------------------------------------------------
// rdu_delay
// Enable-gated shift line that carries side data alongside the arithmetic.
// ----------------------------------------------------------------------------
module rdu_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

@@ src/rdu_div.sv @@
// ----------------------------------------------------------------------------
// rdu_div
// Pipelined restoring divider, one quotient bit per stage.
// Expects num_i < den_i * 2^Q_W.
// ----------------------------------------------------------------------------
module rdu_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int Q_W   = 23
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   low_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [Q_W-1:0]   low_p;
    logic [Q_W-1:0]   quo_p;
    logic [DEN_W:0]   cat;
    logic [DEN_W:0]   diff;

    if (s == 0) begin : g_first
      assign rem_p = DEN_W'(num_i >> Q_W);
      assign low_p = num_i[Q_W-1:0];
      assign quo_p = '0;
      assign den_p = den_i;
    end else begin : g_next
      assign rem_p = rem_q[s-1];
      assign low_p = low_q[s-1];
      assign quo_p = quo_q[s-1];
      assign den_p = den_q[s-1];
    end

    assign cat  = {rem_p, low_p[Q_W-1]};
    assign diff = cat - {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= diff[DEN_W] ? cat[DEN_W-1:0] : diff[DEN_W-1:0];
        low_q[s] <= low_p << 1;
        quo_q[s] <= {quo_p[Q_W-2:0], ~diff[DEN_W]};
        den_q[s] <= den_p;
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

@@ src/rdu_sqrt.sv @@
// ----------------------------------------------------------------------------
// rdu_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, then a
// rounding stage (round to nearest).
// ----------------------------------------------------------------------------
module rdu_sqrt #(
  parameter int IN_W = 52
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [IN_W-1:0] in_i,
  output logic [IN_W/2:0] root_o
);

  localparam int N  = IN_W / 2;
  localparam int RW = N + 1;

  logic [RW-1:0]   rem_q  [N];
  logic [N-1:0]    root_q [N];
  logic [IN_W-1:0] low_q  [N];
  logic [N:0]      out_q;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [RW-1:0]   rem_p;
    logic [N-1:0]    root_p;
    logic [IN_W-1:0] low_p;
    logic [RW+1:0]   cat;
    logic [RW+1:0]   trial;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign low_p  = in_i;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign low_p  = low_q[s-1];
    end

    assign cat   = {rem_p, low_p[IN_W-1 -: 2]};
    assign trial = cat - (RW+2)'({root_p, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= trial[RW+1] ? cat[RW-1:0] : trial[RW-1:0];
        root_q[s] <= {root_p[N-2:0], ~trial[RW+1]};
        low_q[s]  <= low_p << 2;
      end
    end
  end

  // remainder above the root means the true root lies past the half point
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= (rem_q[N-1] > RW'(root_q[N-1])) ? (N+1)'(root_q[N-1]) + 1'b1
                                                : (N+1)'(root_q[N-1]);
    end
  end

  assign root_o = out_q;

endmodule

@@ src/refraction_direction_unit_core.sv @@
// ----------------------------------------------------------------------------
// refraction_direction_unit_core
// Snell refraction direction, normalized, fully pipelined fixed point.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output is not stalled; the index
//   divider, both square roots and the normalizing dividers each resolve one
//   bit per stage
// a stalled output freezes the whole pipeline, nothing is dropped
// reset clears only the valid bits of the stages
module refraction_direction_unit_core
  import rdu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int ENUM_W  = 32;
  localparam int OVF_W   = IDX_W + ETA_W;
  localparam int DPW     = 2 * NW;
  localparam int SUMW    = DPW + 2;
  localparam int CW      = 21;
  localparam int CCW     = 2 * CW;
  localparam int EEW     = 2 * ETA_W;
  localparam int ECPW    = ETA_W + 1 + CW;
  localparam int E2W     = 29;
  localparam int OMW     = 25;
  localparam int PW      = E2W + 1 + OMW;
  localparam int KW      = 37;
  localparam int SQK_W   = KW - 1 + IFRAC;
  localparam int ROOT_W  = SQK_W / 2 + 1;
  localparam int ECW     = 27;
  localparam int AW      = 28;
  localparam int ANW     = AW + NW;
  localparam int EIW     = ETA_W + 1 + NW;
  localparam int TW      = 29;
  localparam int SQW     = 2 * TW;
  localparam int LEN_W   = SQW / 2 + 1;
  localparam int QW      = VEC_FRAC + 1;
  localparam int DNUM_W  = TW + VEC_FRAC;

  localparam int SQ1_LAT = SQK_W / 2 + 1;
  localparam int SQ2_LAT = SQW / 2 + 1;
  localparam int T_K     = 1 + ETA_W + 6;
  localparam int LAT     = T_K + SQ1_LAT + 5 + SQ2_LAT + 1 + QW + 1;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = out_ready_i | ~out_valid_o;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // ---- input stage: internal format, eta dividend -------------------------
  geo_t              geo1_d, geo1_q;
  logic [ENUM_W-1:0] enum_d, enum_q;
  logic [IDX_W-1:0]  eden_q;
  logic              ovf_d, ovf_q;

  always_comb begin
    geo1_d.n0 = to_int(in_word_i.normal_x);
    geo1_d.n1 = to_int(in_word_i.normal_y);
    geo1_d.n2 = to_int(in_word_i.normal_z);
    geo1_d.i0 = -to_int(in_word_i.in_x);
    geo1_d.i1 = -to_int(in_word_i.in_y);
    geo1_d.i2 = -to_int(in_word_i.in_z);
    enum_d = (ENUM_W'(in_word_i.index_from) << IFRAC) + ENUM_W'(in_word_i.index_into >> 1);
    // quotient would not fit the divider, or no divisor at all
    ovf_d = (in_word_i.index_into == '0) ||
            (OVF_W'(enum_d) >= (OVF_W'(in_word_i.index_into) << ETA_W));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo1_q <= geo1_d;
      enum_q <= enum_d;
      eden_q <= in_word_i.index_into;
      ovf_q  <= ovf_d;
    end
  end

  logic [ETA_W-1:0] eta_quo;
  geo_t             geo24;
  logic             ovf24;

  rdu_div #(.NUM_W(ENUM_W), .DEN_W(IDX_W), .Q_W(ETA_W)) u_eta_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (enum_q),
    .den_i (eden_q),
    .quo_o (eta_quo)
  );

  rdu_delay #(.WIDTH($bits(geo_t)), .DEPTH(ETA_W)) u_geo_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (geo1_q),
    .q_o   (geo24)
  );

  rdu_delay #(.WIDTH(1), .DEPTH(ETA_W)) u_ovf_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (ovf_q),
    .q_o   (ovf24)
  );

  // ---- k = 1 - eta^2 (1 - c^2) ---------------------------------------------
  logic [ETA_W-1:0]       eta25_q, eta26_q;
  logic signed [DPW-1:0]  dp0_q, dp1_q, dp2_q;
  logic signed [CW-1:0]   c_q;
  logic [EEW-1:0]         ee_q;
  logic signed [CCW-1:0]  cc_q;
  logic [E2W-1:0]         e2a_q, e2b_q;
  logic signed [ECPW-1:0] ecp_q;
  logic signed [OMW-1:0]  om_q;
  logic signed [ECW-1:0]  ec_q;
  logic signed [PW-1:0]   p_q;
  logic signed [KW-1:0]   k_d;
  logic [SQK_W-1:0]       sqin_q;
  logic                   vres_q;
  logic signed [SUMW-1:0] dsum;

  assign dsum = SUMW'(dp0_q) + SUMW'(dp1_q) + SUMW'(dp2_q);
  assign k_d  = KW'(ONE - rnd16(64'(p_q)));

  always_ff @(posedge clk_i) begin
    if (en) begin
      eta25_q <= (ovf24 || eta_quo > ETA_MAX) ? ETA_MAX : eta_quo;
      dp0_q   <= geo24.n0 * geo24.i0;
      dp1_q   <= geo24.n1 * geo24.i1;
      dp2_q   <= geo24.n2 * geo24.i2;

      c_q     <= CW'(rnd16(64'(dsum)));
      ee_q    <= eta25_q * eta25_q;
      eta26_q <= eta25_q;

      cc_q    <= c_q * c_q;
      e2a_q   <= E2W'(rnd16(64'(ee_q)));
      ecp_q   <= $signed({1'b0, eta26_q}) * c_q;

      om_q    <= OMW'(ONE - rnd16(64'(cc_q)));
      e2b_q   <= e2a_q;
      ec_q    <= ECW'(rnd16(64'(ecp_q)));

      p_q     <= $signed({1'b0, e2b_q}) * om_q;

      // negative k is total internal reflection
      vres_q  <= ~k_d[KW-1];
      sqin_q  <= k_d[KW-1] ? '0 : {k_d[KW-2:0], {IFRAC{1'b0}}};
    end
  end

  logic [ROOT_W-1:0]     root;
  logic signed [ECW-1:0] ec57;
  logic [ETA_W-1:0]      eta58;
  geo_t                  geo58;
  logic                  vres_f;

  rdu_sqrt #(.IN_W(SQK_W)) u_root (
    .clk_i  (clk_i),
    .en_i   (en),
    .in_i   (sqin_q),
    .root_o (root)
  );

  rdu_delay #(.WIDTH(ECW), .DEPTH(2 + SQ1_LAT)) u_ec_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (ec_q),
    .q_o   (ec57)
  );

  rdu_delay #(.WIDTH(ETA_W), .DEPTH(5 + SQ1_LAT + 1)) u_eta_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (eta25_q),
    .q_o   (eta58)
  );

  rdu_delay #(.WIDTH($bits(geo_t)), .DEPTH(6 + SQ1_LAT + 1)) u_geo2_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (geo24),
    .q_o   (geo58)
  );

  rdu_delay #(.WIDTH(1), .DEPTH(LAT - 1 - T_K)) u_vres_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (vres_q),
    .q_o   (vres_f)
  );

  // ---- t = (eta c - sqrt k) n - eta i, then |t|^2 ---------------------------
  logic signed [AW-1:0]  a_q;
  logic signed [ANW-1:0] an_q [3];
  logic signed [EIW-1:0] ei_q [3];
  logic signed [TW-1:0]  t_q  [3];
  logic signed [SQW-1:0] sq_q [3];
  logic [SQW-1:0]        ssum_q;
  logic signed [NW-1:0]  nv   [3];
  logic signed [NW-1:0]  iv   [3];

  assign nv[0] = geo58.n0;
  assign nv[1] = geo58.n1;
  assign nv[2] = geo58.n2;
  assign iv[0] = geo58.i0;
  assign iv[1] = geo58.i1;
  assign iv[2] = geo58.i2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= AW'(ec57) - AW'($signed({1'b0, root}));
      for (int j = 0; j < 3; j++) begin
        an_q[j] <= a_q * nv[j];
        ei_q[j] <= $signed({1'b0, eta58}) * iv[j];
        t_q[j]  <= TW'(rnd16(64'(an_q[j])) - rnd16(64'(ei_q[j])));
        sq_q[j] <= t_q[j] * t_q[j];
      end
      ssum_q <= $unsigned(sq_q[0]) + $unsigned(sq_q[1]) + $unsigned(sq_q[2]);
    end
  end

  logic [LEN_W-1:0]  len;
  logic [3*TW-1:0]   t_pk;
  logic [3*TW-1:0]   t92_pk;

  assign t_pk = {t_q[0], t_q[1], t_q[2]};

  rdu_sqrt #(.IN_W(SQW)) u_len (
    .clk_i  (clk_i),
    .en_i   (en),
    .in_i   (ssum_q),
    .root_o (len)
  );

  rdu_delay #(.WIDTH(3 * TW), .DEPTH(2 + SQ2_LAT)) u_t_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (t_pk),
    .q_o   (t92_pk)
  );

  // ---- normalize: round(t * 2^VEC_FRAC / len) -------------------------------
  logic signed [TW-1:0] t92  [3];
  logic [TW-1:0]        tmag [3];
  logic [DNUM_W-1:0]    dnum_q [3];
  logic [LEN_W-1:0]     dden_q;
  logic [2:0]           neg_q;
  logic                 lz_q;

  assign t92[0] = t92_pk[3*TW-1 -: TW];
  assign t92[1] = t92_pk[2*TW-1 -: TW];
  assign t92[2] = t92_pk[TW-1:0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tmag[j] = t92[j][TW-1] ? $unsigned(-t92[j]) : $unsigned(t92[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dnum_q[j] <= DNUM_W'({tmag[j][TW-2:0], {VEC_FRAC{1'b0}}}) + DNUM_W'(len >> 1);
        neg_q[j]  <= t92[j][TW-1];
      end
      dden_q <= len;
      lz_q   <= (len == '0);
    end
  end

  logic [QW-1:0] quo [3];
  logic [2:0]    neg_f;
  logic          lz_f;

  for (genvar j = 0; j < 3; j++) begin : g_norm
    rdu_div #(.NUM_W(DNUM_W), .DEN_W(LEN_W), .Q_W(QW)) u_norm_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (dnum_q[j]),
      .den_i (dden_q),
      .quo_o (quo[j])
    );
  end

  rdu_delay #(.WIDTH(4), .DEPTH(QW)) u_sign_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({neg_q, lz_q}),
    .q_o   ({neg_f, lz_f})
  );

  // ---- output register -----------------------------------------------------
  out_word_t out_q;
  vec_t      comp [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      // zero-length or reflected result carries a zero direction
      if (!vres_f || lz_f) begin
        comp[j] = '0;
      end else if (neg_f[j]) begin
        comp[j] = -VEC_WIDTH'(quo[j]);
      end else begin
        comp[j] = VEC_WIDTH'(quo[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.valid_res <= vres_f;
      out_q.out_x     <= comp[0];
      out_q.out_y     <= comp[1];
      out_q.out_z     <= comp[2];
    end
  end

  assign out_word_o = out_q;

  // ---- assertions ------------------------------------------------------------
  localparam logic signed [VEC_WIDTH-1:0] UNIT = VEC_WIDTH'(1) <<< VEC_FRAC;

  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.valid_res |->
      out_word_o.out_x == '0 && out_word_o.out_y == '0 && out_word_o.out_z == '0)
    else $error("reflected word carries a nonzero direction");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.valid_res |->
      out_word_o.out_x <= UNIT && out_word_o.out_x >= -UNIT &&
      out_word_o.out_y <= UNIT && out_word_o.out_y >= -UNIT &&
      out_word_o.out_z <= UNIT && out_word_o.out_z >= -UNIT)
    else $error("normalized component exceeds unit magnitude");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vld_q))
    else $error("pipeline moved while the output was stalled");

endmodule
